### rtl/r3ca_pkg.sv
// shared types and constants for the radius-3 cellular automaton ring
// no dependencies
package r3ca_pkg;

  localparam int RULE_WORDS   = 8;
  localparam int RULE_WORD_W  = 16;
  localparam int RULE_ENTRIES = 128;
  localparam int RADIUS       = 3;
  localparam int NBHD_W       = 2 * RADIUS + 1;
  localparam int ROW_W        = 64;
  localparam int INDEX_W      = 6;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 5;
  localparam int REG_SEL_W    = 3;

  typedef logic [RULE_ENTRIES-1:0] rule_table_t;
  typedef logic [NBHD_W-1:0]       nbhd_t;
  typedef logic [ROW_W-1:0]        row_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_STEP  = 1'b1
  } opcode_t;

  typedef struct packed {
    logic step;
    logic write;
    logic wr_val;
  } cell_ctrl_t;

endpackage

### rtl/r3ca_regs.sv
// rule table register bank behind the apb-style configuration port
// depends on r3ca_pkg
module r3ca_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [r3ca_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [r3ca_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [r3ca_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output r3ca_pkg::rule_table_t            rule_table
);
  import r3ca_pkg::*;

  logic [RULE_WORD_W-1:0] rule_word_r [RULE_WORDS];
  logic [REG_SEL_W-1:0]   reg_sel;
  logic                   wr_en;

  assign reg_sel = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign prdata  = APB_DATA_W'(rule_word_r[reg_sel]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < RULE_WORDS; k++) rule_word_r[k] <= '0;
    end else if (wr_en) begin
      rule_word_r[reg_sel] <= pwdata[RULE_WORD_W-1:0];
    end
  end

  always_comb begin
    for (int k = 0; k < RULE_WORDS; k++) begin
      rule_table[k*RULE_WORD_W +: RULE_WORD_W] = rule_word_r[k];
    end
  end

endmodule

### rtl/r3ca_cell.sv
// one cell of the ring: holds its state and looks up its next state
// depends on r3ca_pkg
module r3ca_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  r3ca_pkg::cell_ctrl_t  ctrl,
  input  logic                  sel,
  input  r3ca_pkg::nbhd_t       nbhd,
  input  r3ca_pkg::rule_table_t rule_table,
  output logic                  state
);
  import r3ca_pkg::*;

  logic state_r;
  logic state_nxt;

  always_comb begin
    state_nxt = state_r;
    if (ctrl.step) begin
      state_nxt = rule_table[nbhd];
    end else if (ctrl.write && sel) begin
      state_nxt = ctrl.wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign state = state_r;

endmodule

### rtl/radius3_cellular_automaton_ring_core.sv
// radius-3 binary cellular automaton on a ring, top level
// an item's result is valid the cycle after its transfer; one item per cycle
// unless out_ready stalls; every cell updates in parallel from its neighbors
// the cell registers double as the result register, held until taken
// reset: synchronous active-low rst_n clears all cells, rule words and out_valid
// depends on r3ca_pkg, r3ca_regs, r3ca_cell
module radius3_cellular_automaton_ring_core #(
  parameter int CELLS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_opcode,
  input  logic [r3ca_pkg::INDEX_W-1:0]     in_cell_index,
  input  logic                             in_cell_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [r3ca_pkg::ROW_W-1:0]       out_row_state,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [r3ca_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [r3ca_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [r3ca_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import r3ca_pkg::*;

  rule_table_t      rule_table;
  cell_ctrl_t       ctrl;
  logic [CELLS-1:0] row;
  logic             in_xfer;
  logic             out_valid_r;
  logic             out_valid_nxt;

  r3ca_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .rule_table (rule_table)
  );

  assign in_ready    = !out_valid_r || out_ready;
  assign in_xfer     = in_valid && in_ready;
  assign ctrl.step   = in_xfer && (opcode_t'(in_opcode) == OP_STEP);
  assign ctrl.write  = in_xfer && (opcode_t'(in_opcode) == OP_WRITE);
  assign ctrl.wr_val = in_cell_value;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    nbhd_t nbhd;
    logic  sel;
    for (genvar d = 0; d < NBHD_W; d++) begin : g_tap
      localparam int Pos = (i + CELLS + d - RADIUS) % CELLS;
      assign nbhd[d] = row[Pos];
    end
    assign sel = (in_cell_index == INDEX_W'(i));
    r3ca_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .sel        (sel),
      .nbhd       (nbhd),
      .rule_table (rule_table),
      .state      (row[i])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_state = ROW_W'(row);

  a_valid_after_xfer : assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid)
    else $error("result not presented after input transfer");

  a_no_accept_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while result stalled");

  a_row_held_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_row_state))
    else $error("row changed while result stalled");

  a_write_beyond_ring : assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_opcode && ({1'b0, in_cell_index} >= (INDEX_W + 1)'(CELLS)))
      |=> $stable(out_row_state))
    else $error("write beyond the ring changed the row");

  a_upper_bits_zero : assert property (@(posedge clk)
    (out_row_state >> CELLS) == '0)
    else $error("row bits beyond the ring are set");

endmodule

### dv/r3ca_row_checker.sv
// checker for the radius-3 cellular automaton ring: watches the item, result and apb
// channels, predicts every row and compares it with the block's output
// depends on r3ca_pkg
module r3ca_row_checker #(
  parameter int CELLS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            in_opcode,
  input  logic [r3ca_pkg::INDEX_W-1:0]    in_cell_index,
  input  logic                            in_cell_value,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [r3ca_pkg::ROW_W-1:0]      out_row_state,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [r3ca_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [r3ca_pkg::APB_DATA_W-1:0] pwdata,
  input  logic                            pready,
  input  logic                            sim_done,
  output int                              fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import r3ca_pkg::*;

  logic [RULE_WORD_W-1:0] rule_word_q [RULE_WORDS];
  row_t                   cell_row_q;
  row_t                   expected_rows [$];
  int                     mismatch_cnt = 0;
  bit                     leftover_done = 1'b0;

  assign fail_count = mismatch_cnt;

  function automatic row_t live_mask();
    row_t m;
    m = '0;
    for (int i = 0; i < CELLS; i++) m[i] = 1'b1;
    return m;
  endfunction

  function automatic rule_table_t current_rules();
    rule_table_t t;
    for (int k = 0; k < RULE_WORDS; k++) t[k*RULE_WORD_W +: RULE_WORD_W] = rule_word_q[k];
    return t;
  endfunction

  function automatic row_t advance_row(row_t row, rule_table_t rules);
    row_t  nxt;
    nbhd_t nb;
    int    p;
    nxt = '0;
    for (int i = 0; i < CELLS; i++) begin
      for (int d = 0; d < NBHD_W; d++) begin
        p = (i + CELLS + d - RADIUS) % CELLS;
        nb[d] = row[p];
      end
      nxt[i] = rules[nb];
    end
    return nxt & live_mask();
  endfunction

  always @(posedge clk) begin : watch
    row_t exp_row;
    row_t next_row;
    if (!rst_n) begin
      for (int k = 0; k < RULE_WORDS; k++) rule_word_q[k] = '0;
      cell_row_q = '0;
      expected_rows.delete();
    end else begin
      // result transfer belongs to an older item, so pop before pushing
      if (out_valid && out_ready) begin
        if (expected_rows.size() == 0) begin
          $error("row_state: no result expected, actual %h", out_row_state);
          mismatch_cnt++;
        end else begin
          exp_row = expected_rows.pop_front();
          if (out_row_state !== exp_row) begin
            $error("row_state mismatch: expected %h, actual %h", exp_row, out_row_state);
            mismatch_cnt++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (opcode_t'(in_opcode) == OP_STEP) begin
          next_row = advance_row(cell_row_q, current_rules());
        end else begin
          next_row = cell_row_q;
          if (int'(in_cell_index) < CELLS) next_row[in_cell_index] = in_cell_value;
        end
        next_row   = next_row & live_mask();
        cell_row_q = next_row;
        expected_rows.push_back(next_row);
      end
      if (psel && penable && pwrite && pready) begin
        rule_word_q[paddr[APB_ADDR_W-1:2]] = pwdata[RULE_WORD_W-1:0];
      end
      if (sim_done && !leftover_done) begin
        leftover_done = 1'b1;
        if (expected_rows.size() != 0) begin
          $error("row_state: %0d expected results never arrived", expected_rows.size());
          mismatch_cnt += expected_rows.size();
        end
      end
    end
  end

endmodule

### dv/tb_radius3_cellular_automaton_ring_core.sv
// testbench top for the radius-3 cellular automaton ring: clock, reset, item and
// apb stimulus, receiver stalls, watchdog and verdict
// depends on r3ca_pkg, r3ca_row_checker and the core rtl
module tb_radius3_cellular_automaton_ring_core;
  timeunit 1ns;
  timeprecision 1ps;
  import r3ca_pkg::*;

  localparam int CELLS       = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT     = 300;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_opcode;
  logic [INDEX_W-1:0]    in_cell_index;
  logic                  in_cell_value;
  logic                  out_valid;
  logic                  out_ready;
  logic [ROW_W-1:0]      out_row_state;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  sim_done;
  int                    fail_count;

  int tx_cnt = 0;
  int rx_cnt = 0;
  int cfg_cnt = 0;
  int idle_cycles = 0;
  int rule_sets = 0;
  bit burst_tx = 1'b0;
  logic [RULE_WORD_W-1:0] rule_plan [RULE_WORDS];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  radius3_cellular_automaton_ring_core #(.CELLS(CELLS)) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_cell_index (in_cell_index),
    .in_cell_value (in_cell_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_row_state (out_row_state),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  r3ca_row_checker #(.CELLS(CELLS)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_cell_index (in_cell_index),
    .in_cell_value (in_cell_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_row_state (out_row_state),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .sim_done      (sim_done),
    .fail_count    (fail_count)
  );

  // transfer counters and watchdog
  always @(posedge clk) begin
    if (in_valid && in_ready) tx_cnt <= tx_cnt + 1;
    if (out_valid && out_ready) rx_cnt <= rx_cnt + 1;
    if (psel && penable && pwrite && pready) cfg_cnt <= cfg_cnt + 1;
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random stalls, stall-free stretches and one long hold-off
  initial begin : rx_side
    int gap_left;
    int cyc;
    bit burst_rx;
    bit hold_done;
    gap_left  = 0;
    cyc       = 0;
    burst_rx  = 1'b0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 150 == 0) burst_rx = ($urandom_range(0, 2) == 0);
      if (!hold_done && rx_cnt >= HOLD_AT) begin
        hold_done = 1'b1;
        gap_left  = HOLD_CYCLES;
      end
      if (gap_left > 0) begin
        out_ready <= 1'b0;
        gap_left--;
      end else begin
        out_ready <= 1'b1;
        if (!burst_rx && $urandom_range(0, 99) < 25) gap_left = pick_gap_len();
      end
    end
  end

  task automatic push_item(opcode_t op, logic [INDEX_W-1:0] idx, logic val);
    int gap;
    gap = 0;
    if (!burst_tx && $urandom_range(0, 99) >= 60) gap = pick_gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_cell_index <= idx;
    in_cell_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic push_cell(int idx, logic val);
    push_item(OP_WRITE, INDEX_W'(idx), val);
  endtask

  task automatic push_step();
    push_item(OP_STEP, INDEX_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tx_cnt != rx_cnt) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic apb_write(int k, logic [RULE_WORD_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * k);
    pwdata  <= {16'($urandom), val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_rule_plan();
    wait_idle();
    for (int k = 0; k < RULE_WORDS; k++) apb_write(k, rule_plan[k]);
    rule_sets++;
  endtask

  task automatic plan_all(logic [RULE_WORD_W-1:0] w);
    for (int k = 0; k < RULE_WORDS; k++) rule_plan[k] = w;
  endtask

  initial begin : stimulus
    int r;
    rst_n         = 1'b0;
    sim_done      = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = 1'b0;
    in_cell_index = '0;
    in_cell_value = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: rules cleared, single cell writes at the row ends and middle
    plan_all(16'h0000);
    apply_rule_plan();
    push_cell(0, 1'b1);
    push_cell(63, 1'b1);
    push_cell(31, 1'b1);
    push_cell(32, 1'b1);
    push_cell(63, 1'b0);
    push_cell(0, 1'b0);
    push_cell(0, 1'b0);
    push_step();

    // every entry set: row fills
    plan_all(16'hFFFF);
    apply_rule_plan();
    push_step();
    push_cell(5, 1'b0);
    push_step();
    push_cell(42, 1'b0);

    // copy the cell three to the left: hole moves up
    plan_all(16'hAAAA);
    apply_rule_plan();
    repeat (3) push_step();

    // copy the cell three to the right: hole moves down and wraps
    for (int k = 0; k < RULE_WORDS; k++) rule_plan[k] = (k < 4) ? 16'h0000 : 16'hFFFF;
    apply_rule_plan();
    repeat (2) push_step();
    push_cell(1, 1'b0);
    push_step();

    // identity rule
    plan_all(16'hFF00);
    apply_rule_plan();
    push_step();
    push_cell(10, 1'b0);
    push_step();

    // random phases with different rule densities
    for (int p = 0; p < 6; p++) begin
      for (int k = 0; k < RULE_WORDS; k++) begin
        case (p)
          1:       rule_plan[k] = 16'($urandom & $urandom & $urandom);
          2:       rule_plan[k] = 16'($urandom | $urandom | $urandom);
          4:       rule_plan[k] = 16'hFFFF ^ (16'h1 << $urandom_range(0, 15));
          default: rule_plan[k] = 16'($urandom);
        endcase
      end
      apply_rule_plan();
      burst_tx = (p % 3 == 2);
      repeat (160) begin
        r = $urandom_range(0, 99);
        if (r < 55) push_step();
        else push_cell($urandom_range(0, 63), 1'($urandom_range(0, 1)));
      end
    end
    burst_tx = 1'b0;

    wait_idle();
    repeat (4) @(negedge clk);
    sim_done <= 1'b1;
    repeat (3) @(posedge clk);
    $display("covered %0d item transfers, %0d row results, %0d rule settings (%0d apb writes)",
             tx_cnt, rx_cnt, rule_sets, cfg_cnt);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/r3ca_pkg.sv
rtl/r3ca_regs.sv
rtl/r3ca_cell.sv
rtl/radius3_cellular_automaton_ring_core.sv
dv/r3ca_row_checker.sv
dv/tb_radius3_cellular_automaton_ring_core.sv
